// ===== sv/toric_ca_decoder_cell_defines.svh =====
// assertion macros for the toric ca decoder cell
// no dependencies; included by the top level only
`ifndef TORIC_CA_DECODER_CELL_DEFINES_SVH
`define TORIC_CA_DECODER_CELL_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TCAD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TCAD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tcad_pkg.sv =====
// types, codes and the local decision rule of the toric ca decoder cell
// no dependencies; used by the top level
package tcad_pkg;

    localparam int MAXH    = 2;
    localparam int NUM_POS = 9;
    localparam int TALLY_W = 5;
    localparam int FRAC_W  = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    typedef logic [TALLY_W-1:0] t_tally;
    typedef logic [2:0]         t_dir;
    typedef logic [3:0]         t_pos;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_tally TALLY_MAX = 5'd31;

    // position codes
    localparam t_pos POS_N  = 4'd0;
    localparam t_pos POS_E  = 4'd1;
    localparam t_pos POS_S  = 4'd2;
    localparam t_pos POS_W  = 4'd3;
    localparam t_pos POS_NE = 4'd4;
    localparam t_pos POS_SE = 4'd5;
    localparam t_pos POS_SW = 4'd6;
    localparam t_pos POS_NW = 4'd7;
    localparam t_pos POS_C  = 4'd8;
    localparam t_pos POS_NONE = 4'd9;

    // correction codes
    localparam t_dir DIR_N    = 3'd0;
    localparam t_dir DIR_E    = 3'd1;
    localparam t_dir DIR_S    = 3'd2;
    localparam t_dir DIR_W    = 3'd3;
    localparam t_dir DIR_NONE = 3'd4;

    // register indexes
    localparam t_cfg_idx CFG_CENTER_ADDR   = 3'd0;
    localparam t_cfg_idx CFG_LEVEL_ADDRS   = 3'd1;
    localparam t_cfg_idx CFG_FRAC_CENTER   = 3'd2;
    localparam t_cfg_idx CFG_FRAC_NEIGHBOR = 3'd3;

    localparam logic [3:0] RST_CENTER_ADDR = 4'd8;
    localparam logic [7:0] RST_LEVEL_ADDRS = 8'd153;
    localparam logic [FRAC_W-1:0] RST_FRAC = 9'd128;

    function automatic t_dir local_rule(input t_pos a, input logic [NUM_POS-1:0] s);
        if (a == POS_C || !s[POS_C]) return DIR_NONE;
        if ((a == POS_NW || a == POS_W || a == POS_SW) && (s[POS_W] || s[POS_NW] || s[POS_SW]))
            return DIR_W;
        if ((a == POS_S || a == POS_SW || a == POS_SE) && (s[POS_S] || s[POS_SW] || s[POS_SE]))
            return DIR_S;
        unique case (a)
            POS_SW: begin
                if (s[POS_S] || s[POS_W]) return DIR_NONE;
                if (s[POS_N]) return DIR_N;
                if (s[POS_E]) return DIR_E;
                if (s[POS_SW]) return DIR_NONE;
                if (s[POS_NW]) return DIR_N;
                return DIR_E;
            end
            POS_W: begin
                if (s[POS_S] || s[POS_W] || s[POS_N]) return DIR_NONE;
                if (s[POS_E]) return DIR_E;
                if (s[POS_SW] || s[POS_NW]) return DIR_NONE;
                return DIR_E;
            end
            POS_NW: begin
                if (s[POS_W] || s[POS_N]) return DIR_NONE;
                if (s[POS_E]) return DIR_E;
                if (s[POS_S]) return DIR_S;
                if (s[POS_NW]) return DIR_NONE;
                if (s[POS_NE]) return DIR_E;
                return s[POS_SW] ? DIR_S : DIR_E;
            end
            POS_N: begin
                if (s[POS_W] || s[POS_N] || s[POS_E]) return DIR_NONE;
                if (s[POS_S]) return DIR_S;
                if (s[POS_NW] || s[POS_NE]) return DIR_NONE;
                return DIR_S;
            end
            POS_NE: begin
                if (s[POS_N] || s[POS_E]) return DIR_NONE;
                if (s[POS_S]) return DIR_S;
                if (s[POS_W]) return DIR_W;
                if (s[POS_NE]) return DIR_NONE;
                if (s[POS_SE]) return DIR_S;
                return DIR_W;
            end
            POS_E: begin
                if (s[POS_N] || s[POS_E] || s[POS_S]) return DIR_NONE;
                if (s[POS_W]) return DIR_W;
                if (s[POS_NE] || s[POS_SE]) return DIR_NONE;
                return DIR_W;
            end
            POS_SE: begin
                if (s[POS_E] || s[POS_S]) return DIR_NONE;
                if (s[POS_W]) return DIR_W;
                if (s[POS_N]) return DIR_N;
                if (s[POS_SE]) return DIR_NONE;
                if (s[POS_SW]) return DIR_W;
                return s[POS_NE] ? DIR_N : DIR_W;
            end
            POS_S: begin
                if (s[POS_E] || s[POS_S] || s[POS_W]) return DIR_NONE;
                if (s[POS_N]) return DIR_N;
                if (s[POS_SE] || s[POS_SW]) return DIR_NONE;
                return DIR_N;
            end
            default: return DIR_NONE;
        endcase
    endfunction

    // lowest pending flip wins
    function automatic t_dir low_dir(input logic [3:0] f);
        if (f[0]) return DIR_N;
        if (f[1]) return DIR_E;
        if (f[2]) return DIR_S;
        if (f[3]) return DIR_W;
        return DIR_NONE;
    endfunction

endpackage

// ===== sv/tcad_in_if.sv =====
// input channel of the toric ca decoder cell: syndromes and neighbor signals
// depends on nothing
interface tcad_in_if;
    logic       valid;
    logic       ready;
    logic       own_syndrome;
    logic [7:0] neighbor_syndromes;
    logic [15:0] incoming_count_signals;
    logic [7:0] incoming_flip_signals;

    modport source (
        output valid, own_syndrome, neighbor_syndromes,
               incoming_count_signals, incoming_flip_signals,
        input  ready
    );
    modport sink (
        input  valid, own_syndrome, neighbor_syndromes,
               incoming_count_signals, incoming_flip_signals,
        output ready
    );
endinterface

// ===== sv/tcad_out_if.sv =====
// output channel of the toric ca decoder cell: correction and cell signals
// depends on nothing
interface tcad_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] correction_dir;
    logic [15:0] count_signals_out;
    logic [7:0] flip_signals_out;

    modport source (
        output valid, correction_dir, count_signals_out, flip_signals_out,
        input  ready
    );
    modport sink (
        input  valid, correction_dir, count_signals_out, flip_signals_out,
        output ready
    );
endinterface

// ===== sv/toric_ca_decoder_cell.sv =====
// one cell of a hierarchical cellular-automaton syndrome decoder
// depends on tcad_pkg, tcad_in_if, tcad_out_if, toric_ca_decoder_cell_defines.svh
//
// usage:
//   i_in carries one automaton tick per beat: the cell's own syndrome, the
//   eight neighbor syndromes and the per-level count and flip signals.
//   o_out returns one beat per tick: the correction direction and the
//   cell's count and flip signals after the tick.
//   the cell state (ages, tallies, signal registers) is advanced at the
//   edge that accepts an input beat; the result sits in the output
//   register from the next cycle.
//   throughput is one tick per cycle while the receiver takes each beat;
//   the tick logic between state and output register (tally threshold compares and local rule) is combinational.
//   i_in.ready stays high while the output register is empty or taken in
//   the same cycle; when the receiver stalls, the held beat stays and
//   input is refused until it is taken.
//   reset zeroes all level state, drops the output beat and loads the
//   register defaults; the user must write the configuration port only while idle, the cell does not check it.
`include "toric_ca_decoder_cell_defines.svh"

module toric_ca_decoder_cell #(
    parameter int LEVELS      = 2,
    parameter int BASE_PERIOD = 4,
    parameter int BLOCK_SIZE  = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcad_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tcad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    tcad_in_if.sink                           i_in,
    tcad_out_if.source                        o_out
);

    localparam int MAXH    = tcad_pkg::MAXH;
    localparam int NPOS    = tcad_pkg::NUM_POS;
    localparam int NUM_HI  = (LEVELS - 1 > MAXH) ? MAXH : LEVELS - 1;
    localparam int PER_MAX = BASE_PERIOD ** MAXH;
    localparam int Q_MAX   = BLOCK_SIZE ** MAXH;
    localparam int AGE_W   = $clog2(PER_MAX);
    localparam int CMP_W   = $clog2(((PER_MAX > Q_MAX) ? PER_MAX : Q_MAX) + 1);
    localparam int PROD_RAW = tcad_pkg::FRAC_W + $clog2(PER_MAX + 1);
    localparam int LHS_W   = tcad_pkg::TALLY_W + 8;
    localparam int PROD_W  = (PROD_RAW > LHS_W) ? PROD_RAW : LHS_W;

    // configuration registers
    logic [3:0]                     r_center_addr;
    logic [7:0]                     r_level_addrs;
    logic [tcad_pkg::FRAC_W-1:0]    r_frac_center;
    logic [tcad_pkg::FRAC_W-1:0]    r_frac_neighbor;

    // level state
    logic [AGE_W-1:0]      r_age   [MAXH];
    tcad_pkg::t_tally      r_tally [MAXH][NPOS];
    logic [3:0]            r_flip  [MAXH];

    logic [AGE_W-1:0]      n_age   [MAXH];
    tcad_pkg::t_tally      n_tally [MAXH][NPOS];
    logic [7:0]            n_cnt   [MAXH];
    logic [3:0]            n_flip  [MAXH];

    logic                  w_issue [MAXH];
    logic                  w_exam  [MAXH];
    tcad_pkg::t_dir        w_hit_dir [MAXH];

    // output register
    logic                  r_out_valid;
    tcad_pkg::t_dir        r_corr;
    logic [15:0]           r_cnt_out;
    logic [7:0]            r_flip_out;

    tcad_pkg::t_dir        n_corr;
    logic [15:0]           n_cnt_out;
    logic [7:0]            n_flip_out;
    logic [NPOS-1:0]       w_syn;
    logic                  w_acc;
    logic                  w_open;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_syn      = {i_in.own_syndrome, i_in.neighbor_syndromes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_addr   <= tcad_pkg::RST_CENTER_ADDR;
            r_level_addrs   <= tcad_pkg::RST_LEVEL_ADDRS;
            r_frac_center   <= tcad_pkg::RST_FRAC;
            r_frac_neighbor <= tcad_pkg::RST_FRAC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcad_pkg::CFG_CENTER_ADDR:   r_center_addr   <= i_cfg_data[3:0];
                tcad_pkg::CFG_LEVEL_ADDRS:   r_level_addrs   <= i_cfg_data[7:0];
                tcad_pkg::CFG_FRAC_CENTER:   r_frac_center   <= i_cfg_data;
                tcad_pkg::CFG_FRAC_NEIGHBOR: r_frac_neighbor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < MAXH; k++) begin : g_lvl
        if (k < NUM_HI) begin : g_on
            localparam int PER_K = BASE_PERIOD ** (k + 1);
            localparam int Q_K   = BLOCK_SIZE ** (k + 1);
            localparam logic [PROD_W-1:0] PER_V = PROD_W'(PER_K);

            tcad_pkg::t_pos         addr;
            logic                   is_rep;
            logic [AGE_W:0]         age_inc;
            logic [7:0]             nc;
            logic [3:0]             nf;
            tcad_pkg::t_tally       tal_s [NPOS];
            logic [NPOS-1:0]        cs;
            tcad_pkg::t_dir         d;
            logic [3:0]             flip_s;
            logic [3:0]             flip_set;
            logic [3:0]             low;
            logic                   wrap;
            logic                   hit;
            logic                   inc;
            logic [tcad_pkg::FRAC_W-1:0] f;

            always_comb begin
                addr    = r_level_addrs[4*k +: 4];
                is_rep  = addr < tcad_pkg::POS_NONE;
                nc      = i_in.incoming_count_signals[8*k +: 8];
                nf      = i_in.incoming_flip_signals[4*k +: 4];
                age_inc = {1'b0, r_age[k]} + 1'b1;
                n_age[k] = (CMP_W'(age_inc) == CMP_W'(PER_K)) ? '0 : age_inc[AGE_W-1:0];

                // per-level step
                for (int i = 0; i < NPOS; i++) begin
                    if (i == NPOS - 1) inc = i_in.own_syndrome;
                    else               inc = nc[3'(i) ^ 3'd2];
                    if (is_rep && inc && r_tally[k][i] != tcad_pkg::TALLY_MAX)
                        tal_s[i] = r_tally[k][i] + 1'b1;
                    else
                        tal_s[i] = r_tally[k][i];
                end
                n_cnt[k] = is_rep ? {8{i_in.own_syndrome}} : nc;
                flip_s   = is_rep ? r_flip[k] : nf;

                // coarse syndrome at period wrap
                for (int i = 0; i < NPOS; i++) begin
                    f = (i == NPOS - 1) ? r_frac_center : r_frac_neighbor;
                    cs[i] = PROD_W'({tal_s[i], 8'h00}) >= PROD_W'(f) * PER_V;
                end
                d        = tcad_pkg::local_rule(addr, cs);
                flip_set = flip_s;
                if (d != tcad_pkg::DIR_NONE) flip_set = flip_s | (4'b0001 << d[1:0]);

                wrap = is_rep && n_age[k] == '0;
                hit  = !wrap && CMP_W'(n_age[k]) == CMP_W'(Q_K);
                low  = flip_s & (~flip_s + 4'd1);
                w_issue[k]   = hit && (|flip_s);
                w_hit_dir[k] = tcad_pkg::low_dir(flip_s);

                // commit: tally clear and flip updates only when this level is examined
                for (int i = 0; i < NPOS; i++)
                    n_tally[k][i] = (w_exam[k] && wrap) ? '0 : tal_s[i];
                if (!w_exam[k])  n_flip[k] = flip_s;
                else if (wrap)   n_flip[k] = flip_set;
                else if (hit)    n_flip[k] = flip_s & ~low;
                else             n_flip[k] = flip_s;
            end
        end else begin : g_off
            always_comb begin
                n_age[k]     = '0;
                n_cnt[k]     = '0;
                n_flip[k]    = '0;
                w_issue[k]   = 1'b0;
                w_hit_dir[k] = tcad_pkg::DIR_NONE;
                for (int i = 0; i < NPOS; i++) n_tally[k][i] = '0;
            end
        end
    end

    // decision: lowest issuing level ends it; with none issuing, the local rule decides
    always_comb begin
        w_open = 1'b1;
        n_corr = tcad_pkg::DIR_NONE;
        for (int k = 0; k < MAXH; k++) begin
            w_exam[k] = w_open;
            if (w_open && w_issue[k]) begin
                n_corr = w_hit_dir[k];
                w_open = 1'b0;
            end
        end
        if (w_open) n_corr = tcad_pkg::local_rule(r_center_addr, w_syn);
        for (int k = 0; k < MAXH; k++) begin
            n_cnt_out[8*k +: 8]  = n_cnt[k];
            n_flip_out[4*k +: 4] = n_flip[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAXH; k++) begin
                r_age[k]  <= '0;
                r_flip[k] <= '0;
                for (int i = 0; i < NPOS; i++) r_tally[k][i] <= '0;
            end
        end else if (w_acc) begin
            r_age   <= n_age;
            r_flip  <= n_flip;
            r_tally <= n_tally;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_corr     <= n_corr;
            r_cnt_out  <= n_cnt_out;
            r_flip_out <= n_flip_out;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.correction_dir    = r_corr;
    assign o_out.count_signals_out = r_cnt_out;
    assign o_out.flip_signals_out  = r_flip_out;

    `TCAD_ASSERT_NXT(a_acc_gives_beat, i_clk, i_rst_n, w_acc, r_out_valid, "accepted tick lost its beat")
    `TCAD_ASSERT_NXT(a_idle_holds_age, i_clk, i_rst_n, !w_acc, $stable(r_age[0]), "age moved without a tick")
    `TCAD_ASSERT_IMP(a_age_in_period, i_clk, i_rst_n, 1'b1, CMP_W'(r_age[0]) < CMP_W'(BASE_PERIOD), "level age beyond period")

endmodule
